>>> sv/spi_nor_flash_command_sequencer_macros.svh
// assertion macros for the spi nor flash command sequencer checker
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SCS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scs assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define SCS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scs assertion failed");

`endif

>>> sv/scs_pkg.sv
// types, codes and constants shared by the spi nor flash command sequencer
package scs_pkg;

	localparam int PAGE_BYTES = 256;
	localparam int PB_AW      = $clog2(PAGE_BYTES);
	localparam int PTR_W      = PB_AW + 1;

	localparam int IQ_DEPTH = 2;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);

	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	localparam logic [7:0] OP_ID       = 8'h90;
	localparam logic [7:0] OP_WREN     = 8'h06;
	localparam logic [7:0] OP_ERASE    = 8'h20;
	localparam logic [7:0] OP_STATUS   = 8'h05;
	localparam logic [7:0] OP_PROG     = 8'h02;
	localparam logic [7:0] OP_READ     = 8'h03;
	localparam logic [7:0] STATUS_BUSY = 8'h01;
	localparam logic [7:0] ID_TX_HI    = 8'hAA;
	localparam logic [7:0] ID_TX_LO    = 8'h66;
	localparam logic [7:0] POLL_ERASE  = 8'hEE;
	localparam logic [7:0] POLL_PROG   = 8'hFF;
	localparam logic [7:0] DUMMY_BYTE  = 8'h11;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_START = 2'd1,
		REQ_XCHG  = 2'd2,
		REQ_NONE  = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		CMD_ID    = 2'd0,
		CMD_ERASE = 2'd1,
		CMD_PROG  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_WEN   = 4'd1,
		PH_OPC   = 4'd2,
		PH_A2    = 4'd3,
		PH_A1    = 4'd4,
		PH_A0    = 4'd5,
		PH_DATA  = 4'd6,
		PH_STCMD = 4'd7,
		PH_POLL  = 4'd8,
		PH_RDAT  = 4'd9,
		PH_IDM   = 4'd10,
		PH_IDD   = 4'd11
	} phase_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  command;
		logic [23:0] flash_address;
		logic [15:0] byte_count;
		logic [7:0]  buffer_index;
		logic [7:0]  write_byte;
		logic [7:0]  rx_byte;
	} req_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        cs_pulse_before;
		logic        cs_release;
		logic        data_valid;
		logic [15:0] read_value;
		logic        done_res;
		logic        request_error;
	} res_t;

	typedef struct packed {
		req_kind_t        kind;
		cmd_t             command;
		logic [23:0]      address;
		logic [15:0]      count;
		logic             in_range;
		logic [PB_AW-1:0] index;
		logic [7:0]       write_byte;
		logic [7:0]       rx_byte;
	} item_t;

endpackage

>>> sv/scs_front.sv
// front end: takes requests, classifies them and queues them for the sequencer
module scs_front import scs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  req_t  request,
	output logic  item_valid,
	output item_t item,
	input  logic  item_take
);

	item_t            slot_q [IQ_DEPTH];
	logic [IQ_AW-1:0] wr_q;
	logic [IQ_AW-1:0] rd_q;
	logic [IQ_CW-1:0] cnt_q;
	item_t            cls;
	logic             keep;

	assign full       = (cnt_q == IQ_CW'(IQ_DEPTH));
	assign keep       = push && !full && (request.req_type != REQ_NONE);
	assign item_valid = (cnt_q != '0);
	assign item       = slot_q[rd_q];

	always_comb begin
		cls.kind       = req_kind_t'(request.req_type);
		cls.command    = cmd_t'(request.command);
		cls.address    = request.flash_address;
		cls.count      = request.byte_count;
		cls.in_range   = (32'(request.buffer_index) < PAGE_BYTES);
		cls.index      = PB_AW'(request.buffer_index);
		cls.write_byte = request.write_byte;
		cls.rx_byte    = request.rx_byte;
		case (cls.command)
			CMD_ID: begin
				cls.address = '0;
				cls.count   = '0;
			end
			CMD_ERASE: begin
				cls.count = '0;
			end
			CMD_PROG: begin
				if (request.byte_count > 16'(PAGE_BYTES)) begin
					cls.count = 16'(PAGE_BYTES);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (keep) begin
				wr_q <= (wr_q == IQ_AW'(IQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (item_take) begin
				rd_q <= (rd_q == IQ_AW'(IQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + IQ_CW'(keep) - IQ_CW'(item_take);
		end
	end

endmodule

>>> sv/scs_back.sv
// back end: command sequencer state machine with the page buffer
module scs_back import scs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  item_t item,
	output logic  item_take,
	input  logic  res_ready,
	output logic  res_valid,
	output res_t  res
);

	phase_t           phase_q;
	phase_t           phase_n;
	cmd_t             cmd_q;
	cmd_t             cmd_n;
	logic [23:0]      addr_q;
	logic [23:0]      addr_n;
	logic [15:0]      left_q;
	logic [15:0]      left_n;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] ptr_n;
	logic [7:0]       idhi_q;
	logic [7:0]       idhi_n;
	logic [7:0]       page_q [PAGE_BYTES];
	logic [7:0]       rd_data_q;
	logic [PB_AW-1:0] rd_addr;
	logic             buf_we;
	logic             busy;
	logic [15:0]      left_dec;
	logic [PTR_W-1:0] ptr_inc;
	logic             data_more;
	logic             poll_clear;
	logic [7:0]       poll_byte;

	assign item_take  = item_valid && res_ready;
	assign busy       = (phase_q != PH_IDLE);
	assign left_dec   = left_q - 16'd1;
	assign ptr_inc    = ptr_q + 1'b1;
	assign data_more  = (left_dec != '0) && (ptr_inc < PTR_W'(PAGE_BYTES));
	assign poll_clear = ((item.rx_byte & STATUS_BUSY) == 8'h00);
	assign poll_byte  = (cmd_q == CMD_ERASE) ? POLL_ERASE : POLL_PROG;

	// next state
	always_comb begin
		phase_n = phase_q;
		if (item_take) begin
			case (item.kind)
				REQ_START: begin
					if (!busy) begin
						case (item.command)
							CMD_ERASE, CMD_PROG: phase_n = PH_WEN;
							default:             phase_n = PH_OPC;
						endcase
					end
				end
				REQ_XCHG: begin
					case (phase_q)
						PH_WEN: phase_n = PH_OPC;
						PH_OPC: phase_n = PH_A2;
						PH_A2:  phase_n = PH_A1;
						PH_A1:  phase_n = PH_A0;
						PH_A0: begin
							case (cmd_q)
								CMD_ID:   phase_n = PH_IDM;
								CMD_READ: phase_n = (left_q != '0) ? PH_RDAT : PH_IDLE;
								CMD_PROG: phase_n = (left_q != '0) ? PH_DATA : PH_STCMD;
								default:  phase_n = PH_STCMD;
							endcase
						end
						PH_DATA: begin
							if (!data_more) begin
								phase_n = PH_STCMD;
							end
						end
						PH_STCMD: phase_n = PH_POLL;
						PH_POLL: begin
							if (poll_clear) begin
								phase_n = PH_IDLE;
							end
						end
						PH_RDAT: begin
							if (left_dec == '0) begin
								phase_n = PH_IDLE;
							end
						end
						PH_IDM:  phase_n = PH_IDD;
						PH_IDD:  phase_n = PH_IDLE;
						default: phase_n = PH_IDLE;
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// results and datapath
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		buf_we    = 1'b0;
		cmd_n     = cmd_q;
		addr_n    = addr_q;
		left_n    = left_q;
		ptr_n     = ptr_q;
		idhi_n    = idhi_q;
		if (item_take) begin
			case (item.kind)
				REQ_LOAD: begin
					if (busy) begin
						res_valid         = 1'b1;
						res.request_error = 1'b1;
					end else begin
						buf_we = item.in_range;
					end
				end
				REQ_START: begin
					res_valid = 1'b1;
					if (busy) begin
						res.request_error = 1'b1;
					end else begin
						cmd_n        = item.command;
						addr_n       = item.address;
						left_n       = item.count;
						ptr_n        = '0;
						idhi_n       = '0;
						res.tx_valid = 1'b1;
						case (item.command)
							CMD_ID:   res.tx_byte = OP_ID;
							CMD_READ: res.tx_byte = OP_READ;
							default:  res.tx_byte = OP_WREN;
						endcase
					end
				end
				REQ_XCHG: begin
					res_valid = 1'b1;
					case (phase_q)
						PH_WEN: begin
							res.tx_valid        = 1'b1;
							res.tx_byte         = (cmd_q == CMD_ERASE) ? OP_ERASE : OP_PROG;
							res.cs_pulse_before = 1'b1;
						end
						PH_OPC: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = addr_q[23:16];
						end
						PH_A2: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = addr_q[15:8];
						end
						PH_A1: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = addr_q[7:0];
						end
						PH_A0: begin
							if (cmd_q == CMD_ID) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = ID_TX_HI;
							end else if (cmd_q == CMD_READ) begin
								if (left_q != '0) begin
									res.tx_valid = 1'b1;
									res.tx_byte  = DUMMY_BYTE;
								end else begin
									res.cs_release = 1'b1;
									res.done_res   = 1'b1;
								end
							end else if (cmd_q == CMD_PROG && left_q != '0) begin
								ptr_n        = '0;
								res.tx_valid = 1'b1;
								res.tx_byte  = rd_data_q;
							end else begin
								res.tx_valid        = 1'b1;
								res.tx_byte         = OP_STATUS;
								res.cs_pulse_before = 1'b1;
							end
						end
						PH_DATA: begin
							left_n       = left_dec;
							ptr_n        = ptr_inc;
							res.tx_valid = 1'b1;
							if (data_more) begin
								res.tx_byte = rd_data_q;
							end else begin
								res.tx_byte         = OP_STATUS;
								res.cs_pulse_before = 1'b1;
							end
						end
						PH_STCMD: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = poll_byte;
						end
						PH_POLL: begin
							if (poll_clear) begin
								res.cs_release = 1'b1;
								res.done_res   = 1'b1;
							end else begin
								res.tx_valid = 1'b1;
								res.tx_byte  = poll_byte;
							end
						end
						PH_RDAT: begin
							res.data_valid = 1'b1;
							res.read_value = {8'h00, item.rx_byte};
							left_n         = left_dec;
							if (left_dec != '0) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = DUMMY_BYTE;
							end else begin
								res.cs_release = 1'b1;
								res.done_res   = 1'b1;
							end
						end
						PH_IDM: begin
							idhi_n       = item.rx_byte;
							res.tx_valid = 1'b1;
							res.tx_byte  = ID_TX_LO;
						end
						PH_IDD: begin
							res.cs_release = 1'b1;
							res.data_valid = 1'b1;
							res.read_value = {idhi_q, item.rx_byte};
							res.done_res   = 1'b1;
						end
						default: begin
							res.request_error = 1'b1;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// prefetch the byte the next data exchange will send
	assign rd_addr = (phase_n == PH_DATA) ? PB_AW'(ptr_n + 1'b1) : '0;

	always_ff @(posedge clk) begin
		if (buf_we) begin
			page_q[item.index] <= item.write_byte;
		end
		rd_data_q <= page_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= CMD_ID;
			addr_q  <= '0;
			left_q  <= '0;
			ptr_q   <= '0;
			idhi_q  <= '0;
		end else begin
			phase_q <= phase_n;
			cmd_q   <= cmd_n;
			addr_q  <= addr_n;
			left_q  <= left_n;
			ptr_q   <= ptr_n;
			idhi_q  <= idhi_n;
		end
	end

endmodule

>>> sv/scs_outq.sv
// result queue between the sequencer and the result ports
module scs_outq import scs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  res_t in_res,
	output logic ready,
	output logic empty,
	input  logic pop,
	output res_t result
);

	res_t             slot_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_q;
	logic [OQ_AW-1:0] rd_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign ready  = (cnt_q != OQ_CW'(OQ_DEPTH));
	assign empty  = (cnt_q == '0);
	assign wr_en  = in_valid && ready;
	assign rd_en  = pop && !empty;
	assign result = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_q] <= in_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + OQ_CW'(wr_en) - OQ_CW'(rd_en);
		end
	end

endmodule

>>> sv/spi_nor_flash_command_sequencer.sv
// top level of the spi nor flash command sequencer
// The sequencer takes one request per clock while the input queue is not
// full. A request passes a two-entry input queue, the sequencer state
// machine, which handles one request per cycle while the result queue has
// room, and a two-entry result queue; with both queues empty a result is
// registered into the result queue straight from the input queue head.
// Buffer loads while idle and requests of type three give no result. Each
// request costs one phase update and one registered page buffer read,
// which is fetched ahead, so the sustained rate is one request per clock
// while results are popped as fast. No clearing pass runs after reset.
module spi_nor_flash_command_sequencer import scs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	output logic empty,
	input  logic pop,
	output res_t result
);

	logic  item_valid;
	item_t item;
	logic  item_take;
	logic  res_ready;
	logic  res_valid;
	res_t  res;

	scs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.request    (request),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	scs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res        (res)
	);

	scs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_res   (res),
		.ready    (res_ready),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

>>> sv/scs_checker.sv
// port-level checker for the spi nor flash command sequencer, with its bind
`include "spi_nor_flash_command_sequencer_macros.svh"

module scs_checker import scs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input res_t result
);

	`SCS_ASSERT_IMP(a_idle_tx_zero, !empty && !result.tx_valid, result.tx_byte == 8'h00)
	`SCS_ASSERT_IMP(a_error_alone, !empty && result.request_error, !result.tx_valid && !result.data_valid && !result.done_res && !result.cs_release)
	`SCS_ASSERT_IMP(a_done_releases, !empty && result.done_res, result.cs_release && !result.tx_valid)
	`SCS_ASSERT_IMP(a_pulse_has_byte, !empty && result.cs_pulse_before, result.tx_valid)
	`SCS_ASSERT_NXT(a_head_holds, !empty && !pop, !empty && $stable(result))

endmodule

bind spi_nor_flash_command_sequencer scs_checker u_chk (.*);
